// File: hdl/tlct_pkg.sv
// Package for the text line/column tracker.
// Holds the transaction structs, the classification constants and the ratio constants.
// Used by every module of the tracker; depends on nothing.
`default_nettype none

package tlct_pkg;

  // Default width of the internal position counters.
  localparam int COUNT_BITS_DEF = 24;

  // Field widths fixed by the interface.
  localparam int CP_W    = 16;
  localparam int BLEN_W  = 3;
  localparam int LINE_W  = 25;
  localparam int POS_W   = 24;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;

  // Character codes used by the classifier.
  localparam logic [CP_W-1:0] CH_CR    = 16'h000d;
  localparam logic [CP_W-1:0] CH_LF    = 16'h000a;
  localparam logic [CP_W-1:0] CH_SPACE = 16'h0020;
  localparam logic [CP_W-1:0] CH_TAB   = 16'h0009;
  localparam logic [CP_W-1:0] CH_FF    = 16'h000c;
  localparam logic [CP_W-1:0] CH_ZWSP  = 16'h200b;
  localparam logic [CP_W-1:0] CH_LC_A  = 16'h0061;
  localparam logic [CP_W-1:0] CH_LC_Z  = 16'h007a;
  localparam logic [CP_W-1:0] CH_UC_A  = 16'h0041;
  localparam logic [CP_W-1:0] CH_UC_Z  = 16'h005a;
  localparam logic [CP_W-1:0] CH_D0    = 16'h0030;
  localparam logic [CP_W-1:0] CH_D9    = 16'h0039;

  // floor(cr*100/lf) > 300 is the same as cr*100 >= lf*301.
  localparam int RATIO_SCALE = 100;
  localparam int RATIO_LIMIT = 300 + 1;
  // Extra product bits needed for a multiply by RATIO_LIMIT.
  localparam int PROD_XTRA   = $clog2(RATIO_LIMIT + 1);

  // Input transaction.
  typedef struct packed {
    logic [CP_W-1:0]   code_point;
    logic [BLEN_W-1:0] byte_length;
    logic              last_char;
  } tlct_in_t;

  // Classified item held in the queue.
  typedef struct packed {
    logic [BLEN_W-1:0] byte_length;
    logic              last_char;
    logic              is_cr;
    logic              is_lf;
    logic              is_space;
    logic              is_letter;
    logic              is_digit;
  } tlct_item_t;

  // Result transaction.
  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic [LINE_W-1:0] column;
    logic [POS_W-1:0]  char_position;
    logic [POS_W-1:0]  byte_position;
    logic              at_end;
    logic              is_space;
    logic              is_crlf;
    logic              is_letter;
    logic              is_digit;
  } tlct_out_t;

endpackage

`default_nettype wire

// File: hdl/text_line_column_tracker_top.sv
// Top level of the text line/column tracker.
// Instantiates tlct_front, tlct_queue and tlct_back; depends on tlct_pkg.
//
// The tracker takes one decoded character per transaction and returns one result per
// character: estimated 1-based line and column, character and byte positions, an
// end-of-buffer flag and character classes. A character is accepted every clock while the
// four-entry queue behind the classifier has room, and the back part retires one per
// clock while out_stall is low, so the sustained rate is one character per cycle then.
// An accepted character passes through the queue, then counter update, ratio products,
// and compare and select into the output register. Counters saturate at 2^COUNT_BITS - 1;
// once a character flagged as last is seen, further characters change no counter state.
`default_nettype none

module text_line_column_tracker_top #(
  parameter int COUNT_BITS = tlct_pkg::COUNT_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  tlct_pkg::tlct_in_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output tlct_pkg::tlct_out_t  out_data
);

  tlct_pkg::tlct_item_t front_item;
  tlct_pkg::tlct_item_t q_item;
  logic                 q_full;
  logic                 q_valid;
  logic                 q_pop;

  assign in_stall = q_full;

  // Classify the incoming character.
  tlct_front u_front (
    .in_data_i (in_data),
    .item_o    (front_item)
  );

  // Decouple the classifier from the counter pipeline.
  tlct_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (in_valid),
    .push_data_i (front_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_item)
  );

  // Counters, estimate and result register.
  tlct_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_o   (out_data)
  );

endmodule

`default_nettype wire

// File: hdl/tlct_front.sv
// Front part of the tracker: classifies each incoming character.
// Produces the queue entry (byte length, end flag, character classes).
// Depends on tlct_pkg.
`default_nettype none

module tlct_front (
  input  tlct_pkg::tlct_in_t   in_data_i,
  output tlct_pkg::tlct_item_t item_o
);

  logic [tlct_pkg::CP_W-1:0] cp;
  logic                      is_cr;
  logic                      is_lf;

  assign cp    = in_data_i.code_point;
  assign is_cr = (cp == tlct_pkg::CH_CR);
  assign is_lf = (cp == tlct_pkg::CH_LF);

  // Character classes; the back part masks them once the buffer has ended.
  always_comb begin
    item_o.byte_length = in_data_i.byte_length;
    item_o.last_char   = in_data_i.last_char;
    item_o.is_cr       = is_cr;
    item_o.is_lf       = is_lf;
    item_o.is_space    = (cp == tlct_pkg::CH_SPACE) || (cp == tlct_pkg::CH_TAB) ||
                         (cp == tlct_pkg::CH_FF) || (cp == tlct_pkg::CH_ZWSP) ||
                         is_cr || is_lf;
    item_o.is_letter   = ((cp >= tlct_pkg::CH_LC_A) && (cp <= tlct_pkg::CH_LC_Z)) ||
                         ((cp >= tlct_pkg::CH_UC_A) && (cp <= tlct_pkg::CH_UC_Z));
    item_o.is_digit    = (cp >= tlct_pkg::CH_D0) && (cp <= tlct_pkg::CH_D9);
  end

endmodule

`default_nettype wire

// File: hdl/tlct_queue.sv
// Short FIFO between the front and back parts of the tracker.
// Stores classified items; full and empty come from a registered fill count.
// Depends on tlct_pkg.
`default_nettype none

module tlct_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push_i,
  input  tlct_pkg::tlct_item_t  push_data_i,
  output logic                  full_o,
  input  wire                   pop_i,
  output logic                  valid_o,
  output tlct_pkg::tlct_item_t  pop_data_o
);

  localparam int DEPTH = tlct_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  tlct_pkg::tlct_item_t entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full_o     = (count_r == CNT_W'(DEPTH));
  assign valid_o    = (count_r != '0);
  assign pop_data_o = entry_r[rd_ptr_r];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/tlct_back.sv
// Back part of the tracker: saturating counters, line-ending estimate and result register.
// Three stages: counter update, ratio products, compare/select into the output register.
// Depends on tlct_pkg.
`default_nettype none

module tlct_back #(
  parameter int COUNT_BITS = tlct_pkg::COUNT_BITS_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   item_valid_i,
  input  tlct_pkg::tlct_item_t  item_i,
  output logic                  item_pop_o,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output tlct_pkg::tlct_out_t   out_data_o
);

  localparam int CW = COUNT_BITS;
  localparam int PW = COUNT_BITS + tlct_pkg::PROD_XTRA;

  // Running state.
  logic [CW-1:0] cr_r, lf_r, acr_r, alf_r, chr_r, byt_r;
  logic [CW-1:0] cr_nxt, lf_nxt, acr_nxt, alf_nxt, chr_nxt, byt_nxt;
  logic          ended_r, ended_nxt;
  logic [3:0]    flags_nxt;
  logic [CW:0]   byt_sum;

  // Stage 1: snapshot after the update.
  logic          s1_valid_r, s1_valid_nxt;
  logic [CW-1:0] s1_cr_r, s1_lf_r, s1_acr_r, s1_alf_r, s1_chr_r, s1_byt_r;
  logic          s1_ended_r;
  logic [3:0]    s1_flags_r;

  // Stage 2: ratio products and zero/equal tests.
  logic          s2_valid_r, s2_valid_nxt;
  logic [PW-1:0] s2_pcr_r, s2_plf_r;
  logic          s2_cr_nz_r, s2_eq_r;
  logic [CW-1:0] s2_cr_r, s2_lf_r, s2_acr_r, s2_alf_r, s2_chr_r, s2_byt_r;
  logic          s2_ended_r;
  logic [3:0]    s2_flags_r;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  tlct_pkg::tlct_out_t  out_r, out_nxt;

  logic s1_load, s2_load, out_load;
  logic use_cr;
  logic [CW:0] line_full, col_full;

  // Stage advance: each stage moves when the next one is free or emptying.
  assign out_load   = s2_valid_r && (!out_valid_r || !out_stall_i);
  assign s2_load    = s1_valid_r && (!s2_valid_r || out_load);
  assign s1_load    = item_valid_i && (!s1_valid_r || s2_load);
  assign item_pop_o = s1_load;

  // Counter update for one character; nothing changes once the buffer has ended.
  always_comb begin
    cr_nxt    = cr_r;
    lf_nxt    = lf_r;
    acr_nxt   = acr_r;
    alf_nxt   = alf_r;
    chr_nxt   = chr_r;
    byt_nxt   = byt_r;
    ended_nxt = ended_r;
    flags_nxt = '0;
    byt_sum   = {1'b0, byt_r} + (CW+1)'(item_i.byte_length);
    if (!ended_r) begin
      flags_nxt = {item_i.is_space, item_i.is_cr || item_i.is_lf,
                   item_i.is_letter, item_i.is_digit};
      chr_nxt   = (chr_r == '1) ? chr_r : chr_r + 1'b1;
      byt_nxt   = byt_sum[CW] ? '1 : byt_sum[CW-1:0];
      if (item_i.is_cr) begin
        cr_nxt  = (cr_r == '1) ? cr_r : cr_r + 1'b1;
        acr_nxt = '0;
      end else begin
        acr_nxt = (acr_r == '1) ? acr_r : acr_r + 1'b1;
      end
      if (item_i.is_lf) begin
        lf_nxt  = (lf_r == '1) ? lf_r : lf_r + 1'b1;
        alf_nxt = '0;
      end else begin
        alf_nxt = (alf_r == '1) ? alf_r : alf_r + 1'b1;
      end
      ended_nxt = item_i.last_char;
    end
  end

  // CR and LF counts agree on the line when equal; a nonzero CR count with
  // cr*100 >= lf*301 means CR endings dominate (this also covers lf == 0).
  assign use_cr = s2_cr_nz_r && !s2_eq_r && (s2_pcr_r >= s2_plf_r);

  always_comb begin
    line_full = use_cr ? ({1'b0, s2_cr_r} + 1'b1) : ({1'b0, s2_lf_r} + 1'b1);
    col_full  = use_cr ? ({1'b0, s2_acr_r} + 1'b1) : ({1'b0, s2_alf_r} + 1'b1);
    out_nxt.line          = tlct_pkg::LINE_W'(line_full);
    out_nxt.column        = tlct_pkg::LINE_W'(col_full);
    out_nxt.char_position = tlct_pkg::POS_W'(s2_chr_r);
    out_nxt.byte_position = tlct_pkg::POS_W'(s2_byt_r);
    out_nxt.at_end        = s2_ended_r;
    out_nxt.is_space      = s2_flags_r[3];
    out_nxt.is_crlf       = s2_flags_r[2];
    out_nxt.is_letter     = s2_flags_r[1];
    out_nxt.is_digit      = s2_flags_r[0];
  end

  // Valid bits of the three stages.
  always_comb begin
    s1_valid_nxt = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_valid_r);
    s2_valid_nxt = s2_load ? 1'b1 : (out_load ? 1'b0 : s2_valid_r);
    out_valid_nxt = out_load ? 1'b1 : (out_stall_i ? out_valid_r : 1'b0);
  end

  // Control and counter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cr_r        <= '0;
      lf_r        <= '0;
      acr_r       <= '0;
      alf_r       <= '0;
      chr_r       <= '0;
      byt_r       <= '0;
      ended_r     <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        cr_r    <= cr_nxt;
        lf_r    <= lf_nxt;
        acr_r   <= acr_nxt;
        alf_r   <= alf_nxt;
        chr_r   <= chr_nxt;
        byt_r   <= byt_nxt;
        ended_r <= ended_nxt;
      end
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers of the pipeline.
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_cr_r    <= cr_nxt;
      s1_lf_r    <= lf_nxt;
      s1_acr_r   <= acr_nxt;
      s1_alf_r   <= alf_nxt;
      s1_chr_r   <= chr_nxt;
      s1_byt_r   <= byt_nxt;
      s1_ended_r <= ended_nxt;
      s1_flags_r <= flags_nxt;
    end
    if (s2_load) begin
      s2_pcr_r   <= PW'(s1_cr_r) * PW'(tlct_pkg::RATIO_SCALE);
      s2_plf_r   <= PW'(s1_lf_r) * PW'(tlct_pkg::RATIO_LIMIT);
      s2_cr_nz_r <= (s1_cr_r != '0);
      s2_eq_r    <= (s1_cr_r == s1_lf_r);
      s2_cr_r    <= s1_cr_r;
      s2_lf_r    <= s1_lf_r;
      s2_acr_r   <= s1_acr_r;
      s2_alf_r   <= s1_alf_r;
      s2_chr_r   <= s1_chr_r;
      s2_byt_r   <= s1_byt_r;
      s2_ended_r <= s1_ended_r;
      s2_flags_r <= s1_flags_r;
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_r;

endmodule

`default_nettype wire
